FILE: design/fvn_pkg.sv
// Shared constants, register codes and the lattice value lookup table for the noise block.
`default_nettype none
package fvn_pkg;

  localparam int FRAC_BITS   = 16;
  localparam int INT_BITS    = 8;
  localparam int COORD_W     = INT_BITS + FRAC_BITS;
  localparam int FREQ_W      = 16;
  localparam int FREQ_FRAC   = 12;
  localparam int OCT_W       = 4;
  localparam int SEED_W      = 8;
  localparam int NOISE_W     = 16;
  localparam int CFG_DATA_W  = 16;
  localparam int CFG_IDX_W   = 2;
  localparam int WEIGHT_W    = FRAC_BITS + 1;
  localparam int SAMPLE_W    = COORD_W;
  localparam int DEF_MAX_OCTAVES = 8;

  localparam logic [WEIGHT_W-1:0] ONE = WEIGHT_W'(1) << FRAC_BITS;

  localparam logic [SEED_W-1:0] SEED_RST      = '0;
  localparam logic [FREQ_W-1:0] FREQUENCY_RST = FREQ_W'(4096);
  localparam logic [OCT_W-1:0]  OCTAVES_RST   = OCT_W'(7);

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_SEED      = 2'd0,
    CFG_FREQUENCY = 2'd1,
    CFG_OCTAVES   = 2'd2,
    CFG_UNUSED    = 2'd3
  } cfg_index_t;

  localparam logic [7:0] PERM_TABLE [0:255] = '{
    8'd208, 8'd34, 8'd231, 8'd213, 8'd32, 8'd248, 8'd233, 8'd56, 8'd161, 8'd78,
    8'd24, 8'd140, 8'd71, 8'd48, 8'd140, 8'd254, 8'd245, 8'd255, 8'd247, 8'd247,
    8'd40, 8'd185, 8'd248, 8'd251, 8'd245, 8'd28, 8'd124, 8'd204, 8'd204, 8'd76,
    8'd36, 8'd1, 8'd107, 8'd28, 8'd234, 8'd163, 8'd202, 8'd224, 8'd245, 8'd128,
    8'd167, 8'd204, 8'd9, 8'd92, 8'd217, 8'd54, 8'd239, 8'd174, 8'd173, 8'd102,
    8'd193, 8'd189, 8'd190, 8'd121, 8'd100, 8'd108, 8'd167, 8'd44, 8'd43, 8'd77,
    8'd180, 8'd204, 8'd8, 8'd81, 8'd70, 8'd223, 8'd11, 8'd38, 8'd24, 8'd254,
    8'd210, 8'd210, 8'd177, 8'd32, 8'd81, 8'd195, 8'd243, 8'd125, 8'd8, 8'd169,
    8'd112, 8'd32, 8'd97, 8'd53, 8'd195, 8'd13, 8'd203, 8'd9, 8'd47, 8'd104,
    8'd125, 8'd117, 8'd114, 8'd124, 8'd165, 8'd203, 8'd181, 8'd235, 8'd193, 8'd206,
    8'd70, 8'd180, 8'd174, 8'd0, 8'd167, 8'd181, 8'd41, 8'd164, 8'd30, 8'd116,
    8'd127, 8'd198, 8'd245, 8'd146, 8'd87, 8'd224, 8'd149, 8'd206, 8'd57, 8'd4,
    8'd192, 8'd210, 8'd65, 8'd210, 8'd129, 8'd240, 8'd178, 8'd105, 8'd228, 8'd108,
    8'd245, 8'd148, 8'd140, 8'd40, 8'd35, 8'd195, 8'd38, 8'd58, 8'd65, 8'd207,
    8'd215, 8'd253, 8'd65, 8'd85, 8'd208, 8'd76, 8'd62, 8'd3, 8'd237, 8'd55,
    8'd89, 8'd232, 8'd50, 8'd217, 8'd64, 8'd244, 8'd157, 8'd199, 8'd121, 8'd252,
    8'd90, 8'd17, 8'd212, 8'd203, 8'd149, 8'd152, 8'd140, 8'd187, 8'd234, 8'd177,
    8'd73, 8'd174, 8'd193, 8'd100, 8'd192, 8'd143, 8'd97, 8'd53, 8'd145, 8'd135,
    8'd19, 8'd103, 8'd13, 8'd90, 8'd135, 8'd151, 8'd199, 8'd91, 8'd239, 8'd247,
    8'd33, 8'd39, 8'd145, 8'd101, 8'd120, 8'd99, 8'd3, 8'd186, 8'd86, 8'd99,
    8'd41, 8'd237, 8'd203, 8'd111, 8'd79, 8'd220, 8'd135, 8'd158, 8'd42, 8'd30,
    8'd154, 8'd120, 8'd67, 8'd87, 8'd167, 8'd135, 8'd176, 8'd183, 8'd191, 8'd253,
    8'd115, 8'd184, 8'd21, 8'd233, 8'd58, 8'd129, 8'd233, 8'd142, 8'd39, 8'd128,
    8'd211, 8'd118, 8'd137, 8'd139, 8'd255, 8'd114, 8'd20, 8'd218, 8'd113, 8'd154,
    8'd27, 8'd127, 8'd246, 8'd250, 8'd1, 8'd8, 8'd198, 8'd250, 8'd209, 8'd92,
    8'd222, 8'd173, 8'd21, 8'd88, 8'd102, 8'd219
  };

endpackage
`default_nettype wire

FILE: design/fvn_if.sv
// Valid/ready channel interfaces for the sample point and the noise result.
`default_nettype none
interface fvn_point_if;
  logic                       valid;
  logic                       ready;
  logic [fvn_pkg::COORD_W-1:0] x_coord;
  logic [fvn_pkg::COORD_W-1:0] y_coord;
  modport source (output valid, output x_coord, output y_coord, input ready);
  modport sink   (input valid, input x_coord, input y_coord, output ready);
endinterface

interface fvn_noise_if;
  logic                        valid;
  logic                        ready;
  logic [fvn_pkg::NOISE_W-1:0] noise_value;
  modport source (output valid, output noise_value, input ready);
  modport sink   (input valid, input noise_value, output ready);
endinterface
`default_nettype wire

FILE: design/fractal_value_noise_2d.sv
// Top level of the 2-D fractal value noise pipeline.
//
//  channel  | dir | payload                        | transfer when
//  ---------+-----+--------------------------------+----------------------------
//  pt       | in  | x_coord, y_coord (Q8.16)       | pt.valid && pt.ready
//  noise    | out | noise_value (Q0.16)            | noise.valid && noise.ready
//  cfg      | in  | cfg_index, cfg_data            | cfg_write
//
// One point enters per clock while no stage is stalled; a result passes through
// 1 scale stage, 4 octave-lane stages, 2 weighting/sum stages and
// 16 divider stages (one quotient bit each).
// Reset (rst, synchronous) clears the valid bits and loads seed 0,
// frequency 1.0 and 7 octaves.
// Each stage holds when it is full and the one after it cannot take its data,
// so bubbles close up and a stalled result never blocks the input early.
`default_nettype none
module fractal_value_noise_2d #(
  parameter int MAX_OCTAVES = fvn_pkg::DEF_MAX_OCTAVES
) (
  input  wire logic                          clk,
  input  wire logic                          rst,
  fvn_point_if.sink                          pt,
  fvn_noise_if.source                        noise,
  input  wire logic                          cfg_write,
  input  wire logic [fvn_pkg::CFG_IDX_W-1:0] cfg_index,
  input  wire logic [fvn_pkg::CFG_DATA_W-1:0] cfg_data
);
  import fvn_pkg::*;

  localparam int ACC_W  = MAX_OCTAVES + SAMPLE_W;
  localparam int DEN_W  = MAX_OCTAVES + INT_BITS;
  localparam int N_W    = $clog2(MAX_OCTAVES + 1);
  localparam int LANE_0 = 1;
  localparam int TERM_S = LANE_0 + 4;
  localparam int SUM_S  = TERM_S + 1;
  localparam int DIV_0  = SUM_S + 1;
  localparam int NS     = DIV_0 + NOISE_W;
  localparam int SCL_W  = COORD_W + FREQ_W;

  // configuration registers
  logic [SEED_W-1:0] seed;
  logic [FREQ_W-1:0] frequency;
  logic [OCT_W-1:0]  octaves;

  always_ff @(posedge clk) begin
    if (rst) begin
      seed      <= SEED_RST;
      frequency <= FREQUENCY_RST;
      octaves   <= OCTAVES_RST;
    end else if (cfg_write) begin
      unique case (cfg_index_t'(cfg_index))
        CFG_SEED:      seed      <= cfg_data[SEED_W-1:0];
        CFG_FREQUENCY: frequency <= cfg_data[FREQ_W-1:0];
        CFG_OCTAVES:   octaves   <= cfg_data[OCT_W-1:0];
        default:       ;
      endcase
    end
  end

  // clamp the octave count to 1..MAX_OCTAVES
  logic [N_W-1:0]   n_oct;
  logic [DEN_W-1:0] den;
  always_comb begin
    priority if (octaves == '0) begin
      n_oct = N_W'(1);
    end else if (32'(octaves) > MAX_OCTAVES) begin
      n_oct = N_W'(MAX_OCTAVES);
    end else begin
      n_oct = N_W'(octaves);
    end
  end
  // 256 * (2^n - 1); the Q8 sample scale folds into the shift
  assign den = ((DEN_W'(1) << n_oct) - DEN_W'(1)) << INT_BITS;

  // stage valid bits and per-stage advance
  logic [NS-1:0] vld;
  logic [NS-1:0] adv;

  always_comb begin
    adv[NS-1] = !vld[NS-1] || noise.ready;
    for (int k = NS - 2; k >= 0; k--) begin
      adv[k] = !vld[k] || adv[k+1];
    end
  end

  assign pt.ready    = adv[0];
  assign noise.valid = vld[NS-1];

  always_ff @(posedge clk) begin
    if (rst) begin
      vld <= '0;
    end else begin
      if (adv[0]) begin
        vld[0] <= pt.valid;
      end
      for (int k = 1; k < NS; k++) begin
        if (adv[k]) begin
          vld[k] <= vld[k-1];
        end
      end
    end
  end

  // stage 0: scale by frequency (Q4.12), wrap the integer part to 8 bits
  logic [SCL_W-1:0]   xs, ys;
  logic [COORD_W-1:0] xa, ya;
  assign xs = SCL_W'(pt.x_coord) * SCL_W'(frequency);
  assign ys = SCL_W'(pt.y_coord) * SCL_W'(frequency);

  always_ff @(posedge clk) begin
    if (adv[0]) begin
      xa <= xs[FREQ_FRAC +: COORD_W];
      ya <= ys[FREQ_FRAC +: COORD_W];
    end
  end

  // one lane per octave; lane i samples at coordinates doubled i times
  logic [SAMPLE_W-1:0] smp [0:MAX_OCTAVES-1];
  for (genvar i = 0; i < MAX_OCTAVES; i++) begin : g_lane
    fvn_octave #(.LEVEL(i)) u_oct (
      .clk    (clk),
      .en     (adv[LANE_0 +: 4]),
      .xa     (xa),
      .ya     (ya),
      .seed   (seed),
      .sample (smp[i])
    );
  end

  // weight octave i by 2^(n-1-i); drop octaves past the count
  logic [ACC_W-1:0] term [0:MAX_OCTAVES-1];
  always_ff @(posedge clk) begin
    if (adv[TERM_S]) begin
      for (int i = 0; i < MAX_OCTAVES; i++) begin
        if (N_W'(i) < n_oct) begin
          term[i] <= ACC_W'(smp[i]) << (n_oct - N_W'(1) - N_W'(i));
        end else begin
          term[i] <= '0;
        end
      end
    end
  end

  logic [ACC_W-1:0] acc, acc_next;
  always_comb begin
    acc_next = '0;
    for (int i = 0; i < MAX_OCTAVES; i++) begin
      acc_next = acc_next + term[i];
    end
  end

  always_ff @(posedge clk) begin
    if (adv[SUM_S]) begin
      acc <= acc_next;
    end
  end

  // normalize: quotient never exceeds 65280, so no saturation is needed
  fvn_div #(.NUM_W(ACC_W), .DEN_W(DEN_W)) u_div (
    .clk (clk),
    .en  (adv[DIV_0 +: NOISE_W]),
    .num (acc),
    .den (den),
    .quo (noise.noise_value)
  );

endmodule
`default_nettype wire

FILE: design/fvn_octave.sv
// One octave lane: smoothstep weights, lattice lookups and bilinear blend, four stages.
`default_nettype none
module fvn_octave #(
  parameter int LEVEL = 0
) (
  input  wire logic                          clk,
  input  wire logic [3:0]                    en,
  input  wire logic [fvn_pkg::COORD_W-1:0]   xa,
  input  wire logic [fvn_pkg::COORD_W-1:0]   ya,
  input  wire logic [fvn_pkg::SEED_W-1:0]    seed,
  output logic      [fvn_pkg::SAMPLE_W-1:0]  sample
);
  import fvn_pkg::*;

  localparam int PROD_W  = 2 * FRAC_BITS;
  localparam int SPAN_W  = FRAC_BITS + 2;
  localparam int SMUL_W  = FRAC_BITS + SPAN_W;
  localparam int MIX_W   = INT_BITS + WEIGHT_W;
  localparam int MIX2_W  = MIX_W + WEIGHT_W + 1;

  logic [COORD_W-1:0]   cx, cy;
  logic [PROD_W-1:0]    fxx, fyy;
  logic [FRAC_BITS-1:0] fx, fy, f2x, f2y;
  logic [INT_BITS-1:0]  xi, r0, r1;
  logic [7:0]           yrow0, yrow1;

  assign cx = xa << LEVEL;
  assign cy = ya << LEVEL;
  assign fxx = PROD_W'(cx[FRAC_BITS-1:0]) * PROD_W'(cx[FRAC_BITS-1:0]);
  assign fyy = PROD_W'(cy[FRAC_BITS-1:0]) * PROD_W'(cy[FRAC_BITS-1:0]);
  assign yrow0 = cy[COORD_W-1:FRAC_BITS] + seed;
  assign yrow1 = yrow0 + 8'd1;

  always_ff @(posedge clk) begin
    if (en[0]) begin
      fx  <= cx[FRAC_BITS-1:0];
      fy  <= cy[FRAC_BITS-1:0];
      f2x <= fxx[PROD_W-1:FRAC_BITS];
      f2y <= fyy[PROD_W-1:FRAC_BITS];
      xi  <= cx[COORD_W-1:FRAC_BITS];
      r0  <= PERM_TABLE[yrow0];
      r1  <= PERM_TABLE[yrow1];
    end
  end

  // smoothstep: f2 * (3 - 2f)
  logic [SMUL_W-1:0]   sx, sy;
  logic [WEIGHT_W-1:0] wx, wy, wy2;
  logic [7:0]          i00, i01, i10, i11;
  logic [7:0]          p00, p01, p10, p11;

  assign sx = SMUL_W'(f2x) * (SMUL_W'(3) * SMUL_W'(ONE) - (SMUL_W'(fx) << 1));
  assign sy = SMUL_W'(f2y) * (SMUL_W'(3) * SMUL_W'(ONE) - (SMUL_W'(fy) << 1));
  assign i00 = r0 + xi;
  assign i01 = i00 + 8'd1;
  assign i10 = r1 + xi;
  assign i11 = i10 + 8'd1;

  always_ff @(posedge clk) begin
    if (en[1]) begin
      wx  <= sx[FRAC_BITS +: WEIGHT_W];
      wy  <= sy[FRAC_BITS +: WEIGHT_W];
      p00 <= PERM_TABLE[i00];
      p01 <= PERM_TABLE[i01];
      p10 <= PERM_TABLE[i10];
      p11 <= PERM_TABLE[i11];
    end
  end

  // corner values are whole integers, so the row blend is exact
  logic [MIX_W-1:0] lo, hi, lo_n, hi_n;
  assign lo_n = MIX_W'(p00) * MIX_W'(ONE - wx) + MIX_W'(p01) * MIX_W'(wx);
  assign hi_n = MIX_W'(p10) * MIX_W'(ONE - wx) + MIX_W'(p11) * MIX_W'(wx);

  always_ff @(posedge clk) begin
    if (en[2]) begin
      lo  <= lo_n;
      hi  <= hi_n;
      wy2 <= wy;
    end
  end

  logic [MIX2_W-1:0] col;
  assign col = MIX2_W'(lo) * MIX2_W'(ONE - wy2) + MIX2_W'(hi) * MIX2_W'(wy2);

  always_ff @(posedge clk) begin
    if (en[3]) begin
      sample <= col[FRAC_BITS +: SAMPLE_W];
    end
  end

endmodule
`default_nettype wire

FILE: design/fvn_div.sv
// Pipelined restoring divider, one quotient bit per stage, for the weight normalization.
`default_nettype none
module fvn_div #(
  parameter int NUM_W = 32,
  parameter int DEN_W = 16
) (
  input  wire logic                          clk,
  input  wire logic [fvn_pkg::NOISE_W-1:0]   en,
  input  wire logic [NUM_W-1:0]              num,
  input  wire logic [DEN_W-1:0]              den,
  output logic      [fvn_pkg::NOISE_W-1:0]   quo
);
  import fvn_pkg::*;

  logic [NUM_W-1:0]   rem [1:NOISE_W-1];
  logic [NOISE_W-1:0] qv  [1:NOISE_W];

  for (genvar k = 0; k < NOISE_W; k++) begin : g_bit
    localparam int SH = NOISE_W - 1 - k;
    logic [NUM_W-1:0]   rem_in;
    logic [NOISE_W-1:0] q_in;
    logic [NUM_W-1:0]   cand;
    logic               take;
    if (k == 0) begin : g_head
      assign rem_in = num;
      assign q_in   = '0;
    end else begin : g_body
      assign rem_in = rem[k];
      assign q_in   = qv[k];
    end
    assign cand = NUM_W'(den) << SH;
    assign take = rem_in >= cand;
    always_ff @(posedge clk) begin
      if (en[k]) begin
        qv[k+1] <= {q_in[NOISE_W-2:0], take};
      end
    end
    // the last stage only needs its quotient bit
    if (k < NOISE_W - 1) begin : g_rem
      always_ff @(posedge clk) begin
        if (en[k]) begin
          rem[k+1] <= take ? rem_in - cand : rem_in;
        end
      end
    end
  end

  assign quo = qv[NOISE_W];

endmodule
`default_nettype wire
